[rtl/urxbd_pkg.sv]
package urxbd_pkg;

  // Receive phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_START = 4'b0010,
    PH_DATA  = 4'b0100,
    PH_BREAK = 4'b1000
  } rx_phase_e;

  localparam logic [15:0] BIT_PERIOD_RESET = 16'd16;
  localparam logic [3:0]  BREAK_ZEROS      = 4'd13;
  localparam logic [3:0]  DATA_BITS        = 4'd8;

  // floor(x/3) for 16-bit x as (x * ceil(2^17/3)) >> 17
  localparam logic [16:0] THIRD_MUL   = 17'd43691;
  localparam int unsigned THIRD_SHIFT = 17;

  // One result per sample
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] rx_byte;
    logic       break_seen;
    logic       receiving;
  } result_t;

endpackage

[rtl/urxbd_if.sv]
// Sample channel: one line sample per transaction
interface urxbd_in_if;
  logic valid;
  logic ready;
  logic line_level;

  modport source (output valid, output line_level, input ready);
  modport sink   (input valid, input line_level, output ready);
endinterface

// Result channel: one result per sample
interface urxbd_out_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] rx_byte;
  logic       break_seen;
  logic       receiving;

  modport source (output valid, output byte_valid, output rx_byte,
                  output break_seen, output receiving, input ready);
  modport sink   (input valid, input byte_valid, input rx_byte,
                  input break_seen, input receiving, output ready);
endinterface

[rtl/urxbd_core.sv]
// Receiver state and the per-sample update
module urxbd_core #(
  parameter int unsigned TIME_BITS = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                level_i,
  input  logic [15:0]         bit_period_i,
  output urxbd_pkg::result_t  result_o
);

  urxbd_pkg::rx_phase_e phase_q, phase_d;
  logic                 prev_q, prev_d;
  logic [TIME_BITS-1:0] elapsed_q, elapsed_d;
  logic [TIME_BITS-1:0] next_q, next_d;
  logic [7:0]           byte_q, byte_d;
  logic [3:0]           cnt_q, cnt_d;
  logic [3:0]           zeros_q, zeros_d;

  logic [32:0]          third_prod;
  logic [15:0]          third;
  logic [TIME_BITS-1:0] elapsed_inc;
  logic [TIME_BITS:0]   next_sum;
  logic [TIME_BITS-1:0] next_adv;
  logic [3:0]           zeros_inc;

  // First sample offset: bit_period / 3 by reciprocal multiply
  assign third_prod = 33'(bit_period_i) * 33'(urxbd_pkg::THIRD_MUL);
  assign third      = third_prod[urxbd_pkg::THIRD_SHIFT +: 16];

  // Saturating time arithmetic, and the zero-sample count
  assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
  assign next_sum    = {1'b0, next_q} + (TIME_BITS+1)'(bit_period_i);
  assign next_adv    = next_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : next_sum[TIME_BITS-1:0];
  assign zeros_inc   = level_i ? zeros_q : zeros_q + 4'd1;

  // Next state and result
  always_comb begin
    phase_d   = phase_q;
    prev_d    = level_i;
    elapsed_d = elapsed_q;
    next_d    = next_q;
    byte_d    = byte_q;
    cnt_d     = cnt_q;
    zeros_d   = zeros_q;
    result_o  = '0;

    if (phase_q == urxbd_pkg::PH_IDLE) begin
      // falling edge opens a frame
      if (!level_i && prev_q) begin
        elapsed_d = '0;
        next_d    = TIME_BITS'(third);
        byte_d    = '0;
        cnt_d     = '0;
        phase_d   = urxbd_pkg::PH_START;
      end
    end else begin
      elapsed_d = elapsed_inc;
      if (elapsed_inc >= next_q) begin
        case (phase_q)
          urxbd_pkg::PH_START: begin
            next_d  = next_adv;
            phase_d = urxbd_pkg::PH_DATA;
          end
          urxbd_pkg::PH_DATA: begin
            next_d  = next_adv;
            zeros_d = zeros_inc;
            if (zeros_inc >= urxbd_pkg::BREAK_ZEROS) begin
              zeros_d              = '0;
              phase_d              = urxbd_pkg::PH_BREAK;
              result_o.break_seen  = 1'b1;
            end else if (cnt_q < urxbd_pkg::DATA_BITS) begin
              byte_d = byte_q | (8'(level_i) << cnt_q[2:0]);
              cnt_d  = cnt_q + 4'd1;
            end else if (level_i) begin
              // high stop sample: deliver the byte
              zeros_d             = '0;
              phase_d             = urxbd_pkg::PH_IDLE;
              result_o.byte_valid = 1'b1;
              result_o.rx_byte    = byte_q;
            end
          end
          urxbd_pkg::PH_BREAK: begin
            if (level_i) begin
              phase_d = urxbd_pkg::PH_IDLE;
            end
          end
          default: begin
            phase_d = urxbd_pkg::PH_IDLE;
          end
        endcase
      end
    end

    result_o.receiving = (phase_d != urxbd_pkg::PH_IDLE);
  end

  // State registers, advance once per sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= urxbd_pkg::PH_IDLE;
      prev_q    <= 1'b0;
      elapsed_q <= '0;
      next_q    <= '0;
      byte_q    <= '0;
      cnt_q     <= '0;
      zeros_q   <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      prev_q    <= prev_d;
      elapsed_q <= elapsed_d;
      next_q    <= next_d;
      byte_q    <= byte_d;
      cnt_q     <= cnt_d;
      zeros_q   <= zeros_d;
    end
  end

endmodule

[rtl/uart_rx_with_break_detect_unit.sv]
// Channel   Dir  Modport  Payload
// in_i      in   sink     line_level (1 bit)
// out_o     out  source   byte_valid, rx_byte[7:0], break_seen, receiving
// cfg       in   -        cfg_we_i, cfg_wdata_i[15:0] (bit_period)
//
// One sample per cycle while out_o is not stalled; each result passes the sample register,
// then the result register behind the receiver update.
// The result register lets the next sample enter while a result waits.
// Reset clears the receiver state, bit_period returns to 16.
// A stalled output holds its result; the pipe fills and in_i.ready drops.
module uart_rx_with_break_detect_unit #(
  parameter int unsigned TIME_BITS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  urxbd_in_if.sink    in_i,
  urxbd_out_if.source out_o
);

  logic               in_vld_q;
  logic               in_lvl_q;
  logic               out_vld_q;
  urxbd_pkg::result_t out_q;
  urxbd_pkg::result_t step_res;
  logic [15:0]        bit_period_q;
  logic               step;

  // Pipe advance
  assign step       = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || step;

  // Bit period register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q <= urxbd_pkg::BIT_PERIOD_RESET;
    end else if (cfg_we_i) begin
      bit_period_q <= cfg_wdata_i;
    end
  end

  // Sample register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_lvl_q <= in_i.line_level;
    end
  end

  urxbd_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .level_i      (in_lvl_q),
    .bit_period_i (bit_period_q),
    .result_o     (step_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= step_res;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.byte_valid = out_q.byte_valid;
  assign out_o.rx_byte    = out_q.rx_byte;
  assign out_o.break_seen = out_q.break_seen;
  assign out_o.receiving  = out_q.receiving;

endmodule
